// ===== hw/rtl/packet_signature_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Packet signature detector assertion macros
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_SIGNATURE_DETECTOR_MACROS_SVH
`define PACKET_SIGNATURE_DETECTOR_MACROS_SVH

// General clocked property with reset qualification
`define PSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A signal holds its value across a stalled cycle of a valid transaction
`define PSD_ASSERT_HOLD(label, vld, stl, sig, msg) \
    `PSD_ASSERT(label, (vld && stl) |=> $stable(sig), msg)

`endif

// ===== hw/rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the packet signature detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

    localparam int unsigned NUM_SIG   = 7;
    localparam int unsigned WIN_BYTES = 10;
    localparam int unsigned SIG_W     = (WIN_BYTES + 1) * 8;

    // Signatures, upper case, right-aligned against the newest byte
    localparam logic [SIG_W-1:0] SIG_TEXT [NUM_SIG] = '{
        "CMD.EXE", "CGI-BIN/PHF", "EXPN", "DECODE", "SITE", "EXEC", "PASS"
    };
    localparam int unsigned SIG_LEN [NUM_SIG] = '{7, 11, 4, 6, 4, 4, 4};

    // Bit positions within the seen vector
    localparam int unsigned SIG_CMD_EXE = 0;
    localparam int unsigned SIG_CGI_PHF = 1;
    localparam int unsigned SIG_EXPN    = 2;
    localparam int unsigned SIG_DECODE  = 3;
    localparam int unsigned SIG_SITE    = 4;
    localparam int unsigned SIG_EXEC    = 5;
    localparam int unsigned SIG_PASS    = 6;

    localparam logic       KIND_HDR       = 1'b0;
    localparam logic [1:0] PROTO_TCP      = 2'd1;
    localparam logic [1:0] PROTO_ICMP     = 2'd3;
    localparam logic [7:0] ICMP_ECHO_REQ  = 8'd8;
    localparam int unsigned FLAG_SYN_BIT  = 1;
    localparam int unsigned FLAG_ACK_BIT  = 4;

    localparam logic [15:0] WEB_PORT_RST  = 16'd80;
    localparam logic [15:0] MAIL_PORT_RST = 16'd25;
    localparam logic [15:0] FTP_PORT_RST  = 16'd21;
    localparam logic [15:0] POP3_PORT_RST = 16'd110;

    typedef enum logic [1:0] {
        CFG_WEB_PORT  = 2'd0,
        CFG_MAIL_PORT = 2'd1,
        CFG_FTP_PORT  = 2'd2,
        CFG_POP3_PORT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        kind;
        logic [1:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [7:0]  icmp_type;
        logic [31:0] source_addr;
        logic [7:0]  data_byte;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [1:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [7:0]  icmp_type;
        logic [31:0] source_addr;
    } t_hdr;

    typedef struct packed {
        logic [15:0] web;
        logic [15:0] mail;
        logic [15:0] ftp;
        logic [15:0] pop3;
    } t_ports;

    typedef struct packed {
        logic [31:0] attacker_addr;
        logic        cmd_exe_hit;
        logic        cgi_phf_hit;
        logic        expn_decode_hit;
        logic        site_exec_hit;
        logic        pass_hit;
        logic        ping_hit;
        logic        syn_without_ack;
    } t_alert;

endpackage

// ===== hw/rtl/psd_scan.sv =====
// ----------------------------------------------------------------------------
// psd_scan
// Case-folded byte window and signature flags, one byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_scan
    import psd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_kind,
    input  logic [7:0]         i_data_byte,
    output logic [NUM_SIG-1:0] o_seen_next
);

    logic [WIN_BYTES*8-1:0] r_window, n_window;
    logic [NUM_SIG-1:0]     r_seen, n_seen;
    logic                   r_ended, n_ended;
    logic [7:0]             w_folded;
    logic [SIG_W-1:0]       w_buf;
    logic [NUM_SIG-1:0]     w_hit;

    // only a-z are folded
    assign w_folded = (i_data_byte >= 8'h61 && i_data_byte <= 8'h7A)
                    ? i_data_byte - 8'd32 : i_data_byte;
    assign w_buf    = {r_window, w_folded};

    for (genvar g = 0; g < NUM_SIG; g++) begin : g_sig
        localparam logic [SIG_W-1:0] MASK = {SIG_W{1'b1}} >> (SIG_W - 8 * SIG_LEN[g]);
        assign w_hit[g] = ((w_buf ^ SIG_TEXT[g]) & MASK) == '0;
    end

    always_comb begin
        n_window = r_window;
        n_seen   = r_seen;
        n_ended  = r_ended;
        if (i_kind == KIND_HDR) begin
            n_window = '0;
            n_seen   = '0;
            n_ended  = 1'b0;
        end else if (!r_ended) begin
            if (i_data_byte == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                n_window = {r_window[WIN_BYTES*8-9:0], w_folded};
                n_seen   = r_seen | w_hit;
            end
        end
    end

    assign o_seen_next = n_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
            r_ended  <= 1'b0;
        end else if (i_step) begin
            r_window <= n_window;
            r_seen   <= n_seen;
            r_ended  <= n_ended;
        end
    end

endmodule

// ===== hw/rtl/psd_rules.sv =====
// ----------------------------------------------------------------------------
// psd_rules
// Port rules and header checks that turn the seen flags into an alert vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_rules
    import psd_pkg::*;
(
    input  t_hdr               i_hdr,
    input  t_ports             i_ports,
    input  logic [NUM_SIG-1:0] i_seen,
    output t_alert             o_alert
);

    logic w_tcp, w_web, w_mail, w_ftp, w_pop3;

    always_comb begin
        w_tcp  = i_hdr.protocol == PROTO_TCP;
        w_web  = w_tcp && (i_hdr.dst_port == i_ports.web || i_hdr.src_port == i_ports.web);
        w_mail = w_tcp && i_hdr.dst_port == i_ports.mail;
        w_ftp  = w_tcp && i_hdr.dst_port == i_ports.ftp;
        w_pop3 = w_tcp && i_hdr.dst_port == i_ports.pop3;

        o_alert.attacker_addr   = i_hdr.source_addr;
        o_alert.cmd_exe_hit     = w_web && i_seen[SIG_CMD_EXE];
        o_alert.cgi_phf_hit     = w_web && i_seen[SIG_CGI_PHF];
        o_alert.expn_decode_hit = w_mail && i_seen[SIG_EXPN] && i_seen[SIG_DECODE];
        o_alert.site_exec_hit   = w_ftp && i_seen[SIG_SITE] && i_seen[SIG_EXEC];
        o_alert.pass_hit        = w_pop3 && i_seen[SIG_PASS];
        o_alert.ping_hit        = i_hdr.protocol == PROTO_ICMP
                               && i_hdr.icmp_type == ICMP_ECHO_REQ;
        o_alert.syn_without_ack = w_tcp && i_hdr.tcp_flags[FLAG_SYN_BIT]
                               && !i_hdr.tcp_flags[FLAG_ACK_BIT];
    end

endmodule

// ===== hw/rtl/psd_outq.sv =====
// ----------------------------------------------------------------------------
// psd_outq
// Two-entry result queue; fullness is registered so no stall path crosses it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_outq
    import psd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_alert i_data,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_stall,
    output t_alert o_data
);

    t_alert     r_head, r_tail;
    logic [1:0] r_cnt, n_cnt;
    logic       w_pop;

    assign w_pop   = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_head;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // push is only offered when not full
    always_ff @(posedge i_clk) begin
        if (w_pop && r_cnt == 2'd2) begin
            r_head <= r_tail;
        end else if (i_push && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop))) begin
            r_head <= i_data;
        end
        if (i_push && r_cnt == 2'd1 && !w_pop) begin
            r_tail <= i_data;
        end
    end

endmodule

// ===== hw/rtl/packet_signature_detector.sv =====
// ----------------------------------------------------------------------------
// packet_signature_detector
// Latches packet headers, scans payload bytes for fixed signatures and gives
// one alert vector for each transaction marked last.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  in       | i_in_valid / o_in_stall | i_kind .. i_last, header or one byte
//  out      | o_out_valid/i_out_stall | o_attacker_addr and seven alert flags
//  cfg      | i_cfg_wr_en             | i_cfg_index, i_cfg_data (port numbers)
//
//  One transaction per cycle while the input is not stalled.
//  The input register feeds the scan and rule logic, whose result lands in a
//  two-entry output queue.
//  Reset is synchronous and clears header, window, flags and the queue.
//  The input stalls only when it holds a last item and the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_signature_detector
    import psd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [1:0]  i_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_tcp_flags,
    input  logic [7:0]  i_icmp_type,
    input  logic [31:0] i_source_addr,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_attacker_addr,
    output logic        o_cmd_exe_hit,
    output logic        o_cgi_phf_hit,
    output logic        o_expn_decode_hit,
    output logic        o_site_exec_hit,
    output logic        o_pass_hit,
    output logic        o_ping_hit,
    output logic        o_syn_without_ack,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_item              r_in;
    logic               r_in_valid, n_in_valid;
    t_hdr               r_hdr, n_hdr;
    t_ports             r_ports;
    logic [NUM_SIG-1:0] w_seen_next;
    t_alert             w_alert, w_out;
    logic               w_full, w_adv, w_accept;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ports.web  <= WEB_PORT_RST;
            r_ports.mail <= MAIL_PORT_RST;
            r_ports.ftp  <= FTP_PORT_RST;
            r_ports.pop3 <= POP3_PORT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WEB_PORT:  r_ports.web  <= i_cfg_data;
                CFG_MAIL_PORT: r_ports.mail <= i_cfg_data;
                CFG_FTP_PORT:  r_ports.ftp  <= i_cfg_data;
                CFG_POP3_PORT: r_ports.pop3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign w_adv      = r_in_valid && !(r_in.last && w_full);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= '{kind: i_kind, protocol: i_protocol, src_port: i_src_port,
                      dst_port: i_dst_port, tcp_flags: i_tcp_flags,
                      icmp_type: i_icmp_type, source_addr: i_source_addr,
                      data_byte: i_data_byte, last: i_last};
        end
    end

    // header state as it stands after the item in the input register
    always_comb begin
        n_hdr = r_hdr;
        if (r_in.kind == KIND_HDR) begin
            n_hdr = '{protocol: r_in.protocol, src_port: r_in.src_port,
                      dst_port: r_in.dst_port, tcp_flags: r_in.tcp_flags,
                      icmp_type: r_in.icmp_type, source_addr: r_in.source_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (w_adv) begin
            r_hdr <= n_hdr;
        end
    end

    psd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_kind      (r_in.kind),
        .i_data_byte (r_in.data_byte),
        .o_seen_next (w_seen_next)
    );

    psd_rules u_rules (
        .i_hdr   (n_hdr),
        .i_ports (r_ports),
        .i_seen  (w_seen_next),
        .o_alert (w_alert)
    );

    psd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv && r_in.last),
        .i_data  (w_alert),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_attacker_addr   = w_out.attacker_addr;
    assign o_cmd_exe_hit     = w_out.cmd_exe_hit;
    assign o_cgi_phf_hit     = w_out.cgi_phf_hit;
    assign o_expn_decode_hit = w_out.expn_decode_hit;
    assign o_site_exec_hit   = w_out.site_exec_hit;
    assign o_pass_hit        = w_out.pass_hit;
    assign o_ping_hit        = w_out.ping_hit;
    assign o_syn_without_ack = w_out.syn_without_ack;

endmodule

// ===== hw/rtl/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the packet signature detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_signature_detector_macros.svh"

module psd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_attacker_addr,
    input logic        o_cmd_exe_hit,
    input logic        o_cgi_phf_hit,
    input logic        o_expn_decode_hit,
    input logic        o_site_exec_hit,
    input logic        o_pass_hit,
    input logic        o_ping_hit,
    input logic        o_syn_without_ack
);

    `PSD_ASSERT_HOLD(a_out_valid_hold, o_out_valid, i_out_stall, o_out_valid, "result dropped while stalled")
    `PSD_ASSERT_HOLD(a_out_addr_hold, o_out_valid, i_out_stall, o_attacker_addr, "result changed while stalled")
    // back-pressure only arises from a full result queue
    `PSD_ASSERT(a_stall_needs_result, o_in_stall |-> o_out_valid, "input stalled with no result pending")
    // an icmp alert excludes every tcp-only alert
    `PSD_ASSERT(a_ping_excl, (o_out_valid && o_ping_hit) |-> !(o_cmd_exe_hit || o_cgi_phf_hit || o_expn_decode_hit || o_site_exec_hit || o_pass_hit || o_syn_without_ack), "ping alert mixed with tcp alerts")

endmodule

bind packet_signature_detector psd_checker u_psd_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_signature_detector. A short table of packets
// with hand-typed alerts goes first. Random packets follow under five port
// settings, with signatures, near misses and text terminators mixed into the
// payload. Every alert is checked field by field, against the typed alert or a
// behavioural copy of the header latch, the byte window and the port rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import psd_pkg::*;
();

    localparam logic       KIND_BYTE   = 1'b1;
    localparam logic [1:0] PROTO_OTHER = 2'd0;
    localparam logic [1:0] PROTO_UDP   = 2'd2;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned NUM_PHASES  = 5;

    typedef struct {
        t_item  item;
        bit     typed;
        t_alert want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_item       in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_alert      out_alert;
    logic        cfg_wr_en = 1'b0;
    t_cfg_idx    cfg_index = CFG_WEB_PORT;
    logic [15:0] cfg_data = '0;

    // Signature text, indexed by the SIG_* bit positions
    logic [87:0] sig_words [7] = '{"CMD.EXE", "CGI-BIN/PHF", "EXPN", "DECODE",
                                   "SITE", "EXEC", "PASS"};
    int unsigned sig_lens [7] = '{7, 11, 4, 6, 4, 4, 4};
    // Bytes either side of the letter ranges, where case folding goes wrong
    logic [7:0] fold_edges [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B,
                                   8'h60, 8'h61, 8'h7A, 8'h7B};

    // Behavioural state of the detector
    t_hdr       held_hdr = '0;
    logic [7:0] recent_bytes [10];
    logic [6:0] sigs_found = '0;
    bit         text_done = 1'b0;
    t_ports     rule_ports = '{web: WEB_PORT_RST, mail: MAIL_PORT_RST,
                               ftp: FTP_PORT_RST, pop3: POP3_PORT_RST};

    t_alert      alerts_due [$];
    t_stim_row   stim_rows [$];
    int unsigned items_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          pressure_done = 1'b0;

    packet_signature_detector u_top (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_kind            (in_item.kind),
        .i_protocol        (in_item.protocol),
        .i_src_port        (in_item.src_port),
        .i_dst_port        (in_item.dst_port),
        .i_tcp_flags       (in_item.tcp_flags),
        .i_icmp_type       (in_item.icmp_type),
        .i_source_addr     (in_item.source_addr),
        .i_data_byte       (in_item.data_byte),
        .i_last            (in_item.last),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_attacker_addr   (out_alert.attacker_addr),
        .o_cmd_exe_hit     (out_alert.cmd_exe_hit),
        .o_cgi_phf_hit     (out_alert.cgi_phf_hit),
        .o_expn_decode_hit (out_alert.expn_decode_hit),
        .o_site_exec_hit   (out_alert.site_exec_hit),
        .o_pass_hit        (out_alert.pass_hit),
        .o_ping_hit        (out_alert.ping_hit),
        .o_syn_without_ack (out_alert.syn_without_ack),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Window holds the last ten folded bytes; the new byte completes an
    // eleven byte span against which every signature is right-aligned.
    function automatic void absorb_byte(logic [7:0] c);
        logic [7:0]  span [11];
        int unsigned s, i, base, len;
        bit          hit;
        for (i = 0; i < 10; i++) span[i] = recent_bytes[i];
        span[10] = c;
        for (s = 0; s < 7; s++) begin
            len  = sig_lens[s];
            base = 11 - len;
            hit  = 1'b1;
            for (i = 0; i < len; i++) begin
                if (span[base + i] != sig_words[s][(len - 1 - i) * 8 +: 8]) hit = 1'b0;
            end
            if (hit) sigs_found[s] = 1'b1;
        end
        for (i = 0; i < 9; i++) recent_bytes[i] = recent_bytes[i + 1];
        recent_bytes[9] = c;
    endfunction

    // Applies one transaction to the state; returns 1 with the alert on last
    function automatic bit scan_and_judge(input t_item it, output t_alert a);
        logic [7:0] c;
        bit         tcp, web;
        if (it.kind == KIND_HDR) begin
            held_hdr.protocol    = it.protocol;
            held_hdr.src_port    = it.src_port;
            held_hdr.dst_port    = it.dst_port;
            held_hdr.tcp_flags   = it.tcp_flags;
            held_hdr.icmp_type   = it.icmp_type;
            held_hdr.source_addr = it.source_addr;
            for (int i = 0; i < 10; i++) recent_bytes[i] = 8'h00;
            sigs_found = '0;
            text_done  = 1'b0;
        end else if (!text_done) begin
            c = it.data_byte;
            if (c == 8'h00) begin
                text_done = 1'b1;
            end else begin
                if (c >= "a" && c <= "z") c = c - 8'd32;
                absorb_byte(c);
            end
        end
        a = '0;
        if (!it.last) return 1'b0;
        tcp = (held_hdr.protocol == PROTO_TCP);
        web = tcp && (held_hdr.dst_port == rule_ports.web ||
                      held_hdr.src_port == rule_ports.web);
        a.attacker_addr   = held_hdr.source_addr;
        a.cmd_exe_hit     = web && sigs_found[SIG_CMD_EXE];
        a.cgi_phf_hit     = web && sigs_found[SIG_CGI_PHF];
        a.expn_decode_hit = tcp && held_hdr.dst_port == rule_ports.mail &&
                            sigs_found[SIG_EXPN] && sigs_found[SIG_DECODE];
        a.site_exec_hit   = tcp && held_hdr.dst_port == rule_ports.ftp &&
                            sigs_found[SIG_SITE] && sigs_found[SIG_EXEC];
        a.pass_hit        = tcp && held_hdr.dst_port == rule_ports.pop3 &&
                            sigs_found[SIG_PASS];
        a.ping_hit        = held_hdr.protocol == PROTO_ICMP &&
                            held_hdr.icmp_type == ICMP_ECHO_REQ;
        a.syn_without_ack = tcp && held_hdr.tcp_flags[FLAG_SYN_BIT] &&
                            !held_hdr.tcp_flags[FLAG_ACK_BIT];
        return 1'b1;
    endfunction

    function automatic t_item hdr_item(logic [1:0] proto, logic [15:0] src,
                                       logic [15:0] dst, logic [7:0] flags,
                                       logic [7:0] icmp, logic [31:0] addr,
                                       logic lst);
        t_item it;
        it.kind        = KIND_HDR;
        it.protocol    = proto;
        it.src_port    = src;
        it.dst_port    = dst;
        it.tcp_flags   = flags;
        it.icmp_type   = icmp;
        it.source_addr = addr;
        it.data_byte   = 8'($urandom_range(0, 255));
        it.last        = lst;
        return it;
    endfunction

    // Header fields are noise on a payload byte
    function automatic t_item byte_item(logic [7:0] b, logic lst);
        t_item it;
        it.kind        = KIND_BYTE;
        it.protocol    = 2'($urandom_range(0, 3));
        it.src_port    = 16'($urandom_range(0, 65535));
        it.dst_port    = 16'($urandom_range(0, 65535));
        it.tcp_flags   = 8'($urandom_range(0, 255));
        it.icmp_type   = 8'($urandom_range(0, 255));
        it.source_addr = $urandom;
        it.data_byte   = b;
        it.last        = lst;
        return it;
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 6))
            0: return rule_ports.web;
            1: return rule_ports.mail;
            2: return rule_ports.ftp;
            3: return rule_ports.pop3;
            4: return 16'h0000;
            5: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_item random_header(logic lst);
        logic [1:0]  proto;
        logic [15:0] src;
        logic [7:0]  flags, icmp;
        proto = ($urandom_range(0, 99) < 60) ? PROTO_TCP : 2'($urandom_range(0, 3));
        src   = ($urandom_range(0, 3) == 0) ? rule_ports.web : pick_port();
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) begin
            flags[FLAG_SYN_BIT] = 1'b1;
            flags[FLAG_ACK_BIT] = 1'b0;
        end
        icmp = ($urandom_range(0, 9) < 4) ? ICMP_ECHO_REQ : 8'($urandom_range(0, 255));
        return hdr_item(proto, src, pick_port(), flags, icmp, $urandom, lst);
    endfunction

    function automatic bit steady_stretch();
        return items_accepted >= 900 && items_accepted < 1200;
    endfunction

    task automatic add_row(t_item it, bit typed, t_alert want);
        t_stim_row row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // Offers one transaction and waits for it to be taken
    task automatic send_item(t_item it, bit typed, t_alert want);
        t_alert pred;
        if (!steady_stretch()) begin
            while ($urandom_range(0, 99) < 16) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        items_accepted++;
        if (scan_and_judge(it, pred)) alerts_due.push_back(typed ? want : pred);
    endtask

    task automatic send_random_packet();
        logic [7:0]  text [$];
        logic [87:0] word;
        logic [7:0]  ch;
        int unsigned n_bytes, shape, pick, s, k, len, miss;
        bit          ends;
        shape   = $urandom_range(0, 99);
        n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 16);
        while (text.size() < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                s    = $urandom_range(0, 6);
                len  = sig_lens[s];
                word = sig_words[s];
                miss = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
                for (k = 0; k < len; k++) begin
                    ch = word[(len - 1 - k) * 8 +: 8];
                    if (k == miss) ch = ch ^ 8'h01;
                    if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) ch = ch + 8'd32;
                    text.push_back(ch);
                end
            end else if (pick < 45) begin
                text.push_back(8'h00);
            end else if (pick < 60) begin
                text.push_back(fold_edges[3'($urandom_range(0, 7))]);
            end else begin
                text.push_back(8'($urandom_range(1, 255)));
            end
        end
        // mostly whole packets; some orphan bytes, some packets never closed
        if (shape < 82) begin
            ends = 1'b1;
            send_item(random_header(text.size() == 0), 1'b0, '0);
        end else if (shape < 90) begin
            ends = 1'b1;
            if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            ends = 1'b0;
            send_item(random_header(1'b0), 1'b0, '0);
        end
        for (k = 0; k < text.size(); k++) begin
            send_item(byte_item(text[k], ends && k == text.size() - 1), 1'b0, '0);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_WEB_PORT:  rule_ports.web  = val;
            CFG_MAIL_PORT: rule_ports.mail = val;
            CFG_FTP_PORT:  rule_ports.ftp  = val;
            CFG_POP3_PORT: rule_ports.pop3 = val;
            default: ;
        endcase
    endtask

    // Only while idle: all alerts in, pipeline flushed of trailing bytes
    task automatic program_ports(t_ports p);
        in_valid <= 1'b0;
        while (alerts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_WEB_PORT, p.web);
        write_reg(CFG_MAIL_PORT, p.mail);
        write_reg(CFG_FTP_PORT, p.ftp);
        write_reg(CFG_POP3_PORT, p.pop3);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : alert_check
        t_alert want;
        if (rst_n && out_valid && !out_stall) begin
            if (alerts_due.size() == 0) begin
                $error("alert with none pending, attacker_addr %0h",
                       out_alert.attacker_addr);
                mismatch_count++;
            end else begin
                want = alerts_due.pop_front();
                check_field("attacker_addr", want.attacker_addr, out_alert.attacker_addr);
                check_field("cmd_exe_hit", 32'(want.cmd_exe_hit),
                            32'(out_alert.cmd_exe_hit));
                check_field("cgi_phf_hit", 32'(want.cgi_phf_hit),
                            32'(out_alert.cgi_phf_hit));
                check_field("expn_decode_hit", 32'(want.expn_decode_hit),
                            32'(out_alert.expn_decode_hit));
                check_field("site_exec_hit", 32'(want.site_exec_hit),
                            32'(out_alert.site_exec_hit));
                check_field("pass_hit", 32'(want.pass_hit), 32'(out_alert.pass_hit));
                check_field("ping_hit", 32'(want.ping_hit), 32'(out_alert.ping_hit));
                check_field("syn_without_ack", 32'(want.syn_without_ack),
                            32'(out_alert.syn_without_ack));
            end
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up
    initial begin : out_stall_gen
        forever begin
            @(posedge i_clk);
            if (!pressure_done && items_accepted >= 600) begin
                pressure_done = 1'b1;
                out_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
            end else if (steady_stretch()) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 16);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_ports      phase_ports [NUM_PHASES];
        int unsigned phase_end [NUM_PHASES];

        phase_ports[0] = '{web: 16'd8080, mail: 16'd587, ftp: 16'd2121, pop3: 16'd995};
        phase_ports[1] = '{web: 16'h0000, mail: 16'h0000, ftp: 16'h0000, pop3: 16'h0000};
        phase_ports[2] = '{web: 16'hFFFF, mail: 16'hFFFF, ftp: 16'hFFFF, pop3: 16'hFFFF};
        phase_ports[3] = '{web: 16'($urandom_range(0, 65535)),
                           mail: 16'($urandom_range(0, 65535)),
                           ftp: 16'($urandom_range(0, 65535)),
                           pop3: 16'($urandom_range(0, 65535))};
        phase_ports[4] = '{web: WEB_PORT_RST, mail: MAIL_PORT_RST,
                           ftp: FTP_PORT_RST, pop3: POP3_PORT_RST};
        phase_end = '{370, 720, 1070, 1420, 1775};
        for (int i = 0; i < 10; i++) recent_bytes[i] = 8'h00;

        // alert bits below: cmd, cgi, expn/decode, site/exec, pass, ping, syn
        // payload before any header: judged on the reset header
        add_row(byte_item("x", 1'b1), 1'b1, t_alert'({32'h0, 7'b0000000}));
        add_row(hdr_item(PROTO_TCP, 16'h0000, WEB_PORT_RST, 8'h02, 8'hFF,
                         32'hFFFF_FFFF, 1'b0), 1'b0, '0);
        add_row(byte_item("c", 1'b0), 1'b0, '0);
        add_row(byte_item("m", 1'b0), 1'b0, '0);
        add_row(byte_item("d", 1'b0), 1'b0, '0);
        add_row(byte_item(".", 1'b0), 1'b0, '0);
        add_row(byte_item("E", 1'b0), 1'b0, '0);
        add_row(byte_item("X", 1'b0), 1'b0, '0);
        add_row(byte_item("e", 1'b0), 1'b0, '0);
        // text ends at the zero byte; later bytes are not scanned
        add_row(byte_item(8'h00, 1'b0), 1'b0, '0);
        add_row(byte_item("P", 1'b1), 1'b1, t_alert'({32'hFFFF_FFFF, 7'b1000001}));
        // second last without a new header: same accumulated verdict
        add_row(byte_item("A", 1'b1), 1'b1, t_alert'({32'hFFFF_FFFF, 7'b1000001}));
        add_row(hdr_item(PROTO_ICMP, 16'h0000, 16'h0000, 8'hFF, ICMP_ECHO_REQ,
                         32'h0, 1'b1), 1'b1, t_alert'({32'h0, 7'b0000010}));
        add_row(hdr_item(PROTO_UDP, WEB_PORT_RST, WEB_PORT_RST, 8'h02, 8'h00,
                         32'h1234_5678, 1'b0), 1'b0, '0);
        add_row(byte_item(8'hFF, 1'b1), 1'b1, t_alert'({32'h1234_5678, 7'b0000000}));
        add_row(hdr_item(PROTO_TCP, 16'h0001, POP3_PORT_RST, 8'h12, ICMP_ECHO_REQ,
                         32'h8000_0001, 1'b0), 1'b0, '0);
        add_row(byte_item("p", 1'b0), 1'b0, '0);
        add_row(byte_item("a", 1'b0), 1'b0, '0);
        add_row(byte_item("S", 1'b0), 1'b0, '0);
        add_row(byte_item("s", 1'b0), 1'b0, '0);
        add_row(byte_item(8'h7B, 1'b1), 1'b1, t_alert'({32'h8000_0001, 7'b0000100}));
        add_row(hdr_item(PROTO_OTHER, 16'h0000, 16'h0000, 8'h02, ICMP_ECHO_REQ,
                         32'h0000_0001, 1'b1), 1'b1, t_alert'({32'h1, 7'b0000000}));
        add_row(hdr_item(PROTO_TCP, 16'hFFFF, 16'hFFFF, 8'hFD, 8'h00,
                         32'hFFFF_FFFF, 1'b1), 1'b1,
                t_alert'({32'hFFFF_FFFF, 7'b0000000}));
        add_row(hdr_item(PROTO_TCP, 16'h0000, 16'h0000, 8'hEF, 8'h00,
                         32'hA5A5_A5A5, 1'b1), 1'b1,
                t_alert'({32'hA5A5_A5A5, 7'b0000001}));

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) send_item(stim_rows[r].item, stim_rows[r].typed,
                                         stim_rows[r].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_ports(phase_ports[p]);
            while (items_accepted < phase_end[p]) send_random_packet();
        end

        in_valid <= 1'b0;
        while (alerts_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
